FILE: hw/rtl/mlpf_pkg.sv
// Shared types, constants and codes of the multilink PPP fragmenter.
package mlpf_pkg;

	localparam int SEQ_WIDTH   = 24;
	localparam int HDR_SEQ_W   = 24;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAG_SIZE         = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_SEQUENCE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEND_ADDR_CTRL    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COMPRESS_PROTOCOL = 2'd3;

	localparam logic [15:0] FRAG_SIZE_RESET = 16'd1500;

	localparam logic [7:0] ADDR_BYTE     = 8'hff;
	localparam logic [7:0] CTRL_BYTE     = 8'h03;
	localparam logic [7:0] PROTO_HI_BYTE = 8'h00;
	localparam logic [7:0] PROTO_LO_BYTE = 8'h3d;
	localparam logic [7:0] FLAG_BEGIN    = 8'h80;
	localparam logic [7:0] FLAG_END      = 8'h40;
	localparam logic [7:0] SEQ_HI_MASK   = 8'h0f;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        packet_start;
		logic [15:0] packet_length;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_header;
		logic       fragment_last;
		logic       packet_last;
		logic       run_last;
	} result_t;

	typedef struct packed {
		logic [15:0] frag_size;
		logic        short_sequence;
		logic        send_addr_ctrl;
		logic        compress_protocol;
	} cfg_t;

	typedef struct packed {
		logic [7:0]           data_byte;
		logic                 need_header;
		logic                 flag_begin;
		logic                 flag_end;
		logic [SEQ_WIDTH-1:0] seq;
		logic                 fragment_last;
		logic                 packet_last;
	} entry_t;

	typedef enum logic [3:0] {
		STEP_IDLE,
		STEP_ADDR,
		STEP_CTRL,
		STEP_PROTO_HI,
		STEP_PROTO_LO,
		STEP_FLAGS,
		STEP_SEQ2,
		STEP_SEQ1,
		STEP_SEQ0,
		STEP_DATA
	} step_t;

endpackage

FILE: hw/rtl/mlpf_front.sv
// Front part: tracks packet and fragment counts and classifies each payload byte.
module mlpf_front import mlpf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   accept,
	input  item_t  item,
	output logic   push,
	output entry_t entry
);

	logic [15:0]          pkt_left_q;
	logic [15:0]          frag_left_q;
	logic                 first_pend_q;
	logic [SEQ_WIDTH-1:0] seq_q;

	logic [15:0] pl;
	logic [15:0] fl;
	logic        fp;
	logic [15:0] fs;
	logic [15:0] flen;
	logic [15:0] fl_use;
	logic [15:0] fl_next;
	logic [15:0] pl_next;
	logic        need_hdr;

	always_comb begin
		if (item.packet_start) begin
			pl = (item.packet_length == 16'd0) ? 16'd1 : item.packet_length;
			fl = 16'd0;
			fp = 1'b1;
		end else begin
			pl = pkt_left_q;
			fl = frag_left_q;
			fp = first_pend_q;
		end
		fs       = (cfg.frag_size == 16'd0) ? 16'd1 : cfg.frag_size;
		flen     = (fs < pl) ? fs : pl;
		need_hdr = (fl == 16'd0);
		fl_use   = need_hdr ? flen : fl;
		fl_next  = fl_use - 16'd1;
		pl_next  = pl - 16'd1;
	end

	assign push = accept && (pl != 16'd0);

	always_comb begin
		entry.data_byte     = item.data_byte;
		entry.need_header   = need_hdr;
		entry.flag_begin    = fp;
		entry.flag_end      = (flen == pl);
		entry.seq           = seq_q;
		entry.fragment_last = (fl_next == 16'd0);
		entry.packet_last   = (pl_next == 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_left_q   <= '0;
			frag_left_q  <= '0;
			first_pend_q <= 1'b0;
			seq_q        <= '0;
		end else if (accept) begin
			if (push) begin
				pkt_left_q  <= pl_next;
				frag_left_q <= fl_next;
				if (need_hdr) begin
					seq_q        <= seq_q + SEQ_WIDTH'(1);
					first_pend_q <= 1'b0;
				end else begin
					first_pend_q <= fp;
				end
			end else begin
				pkt_left_q   <= pl;
				frag_left_q  <= fl;
				first_pend_q <= fp;
			end
		end
	end

endmodule

FILE: hw/rtl/mlpf_queue.sv
// Short queue of classified bytes between the front and back parts.
module mlpf_queue import mlpf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   full,
	output logic   empty
);

	entry_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/mlpf_back.sv
// Back part: expands each queued byte into its payload beat, preceded by header bytes when it opens a fragment.
module mlpf_back import mlpf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  entry_t  head,
	input  logic    empty,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	step_t                step_q;
	step_t                step_d;
	step_t                cur;
	step_t                first_hdr;
	logic                 adv;
	logic                 emit;
	result_t              res_d;
	result_t              out_q;
	logic                 out_valid_q;
	logic [HDR_SEQ_W-1:0] seq_ext;
	logic [7:0]           flags;

	assign adv       = !out_valid_q || !result_stall;
	assign emit      = adv && !empty;
	assign first_hdr = cfg.send_addr_ctrl ? STEP_ADDR :
	                   (cfg.compress_protocol ? STEP_PROTO_LO : STEP_PROTO_HI);
	assign cur       = (step_q == STEP_IDLE) ?
	                   (head.need_header ? first_hdr : STEP_DATA) : step_q;
	assign pop       = emit && (cur == STEP_DATA);

	always_comb begin
		step_d = step_q;
		if (emit) begin
			unique case (cur)
				STEP_ADDR:     step_d = STEP_CTRL;
				STEP_CTRL:     step_d = cfg.compress_protocol ? STEP_PROTO_LO : STEP_PROTO_HI;
				STEP_PROTO_HI: step_d = STEP_PROTO_LO;
				STEP_PROTO_LO: step_d = STEP_FLAGS;
				STEP_FLAGS:    step_d = cfg.short_sequence ? STEP_SEQ0 : STEP_SEQ2;
				STEP_SEQ2:     step_d = STEP_SEQ1;
				STEP_SEQ1:     step_d = STEP_SEQ0;
				STEP_SEQ0:     step_d = STEP_DATA;
				default:       step_d = STEP_IDLE;
			endcase
		end
	end

	always_comb begin
		seq_ext = HDR_SEQ_W'(head.seq);
		flags   = (head.flag_begin ? FLAG_BEGIN : 8'h00) | (head.flag_end ? FLAG_END : 8'h00);
		if (cfg.short_sequence) begin
			flags = flags | ({4'h0, seq_ext[11:8]} & SEQ_HI_MASK);
		end
		res_d.is_header     = (cur != STEP_DATA);
		res_d.fragment_last = 1'b0;
		res_d.packet_last   = 1'b0;
		res_d.run_last      = 1'b0;
		unique case (cur)
			STEP_ADDR:     res_d.out_byte = ADDR_BYTE;
			STEP_CTRL:     res_d.out_byte = CTRL_BYTE;
			STEP_PROTO_HI: res_d.out_byte = PROTO_HI_BYTE;
			STEP_PROTO_LO: res_d.out_byte = PROTO_LO_BYTE;
			STEP_FLAGS:    res_d.out_byte = flags;
			STEP_SEQ2:     res_d.out_byte = seq_ext[23:16];
			STEP_SEQ1:     res_d.out_byte = seq_ext[15:8];
			STEP_SEQ0:     res_d.out_byte = seq_ext[7:0];
			STEP_DATA: begin
				res_d.out_byte      = head.data_byte;
				res_d.fragment_last = head.fragment_last;
				res_d.packet_last   = head.packet_last;
				res_d.run_last      = 1'b1;
			end
			default:       res_d.out_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (adv) begin
				out_valid_q <= !empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

FILE: hw/rtl/multilink_ppp_fragmenter_top.sv
// Top level of the multilink PPP fragmenter: configuration registers and part wiring.
//
//   channel  direction  handshake                    beat
//   item     in         item_valid / item_stall      one payload byte with start and length
//   result   out        result_valid / result_stall  one header or payload byte
//   cfg      in         cfg_we                       one register write
//
// A payload byte inside a fragment goes through the queue and the output register; such beats
// flow at one per cycle while result_stall is low. The first byte of a fragment waits while the
// back part emits the link and multilink header bytes, one per unstalled cycle, from its step sequencer.
// A four-entry queue lets the input keep flowing during header insertion until it fills.
// Reset clears counters, queue pointers and the output valid; no clearing pass is needed.
module multilink_ppp_fragmenter_top import mlpf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg_q;
	logic   accept;
	logic   push;
	entry_t entry;
	entry_t head;
	logic   pop;
	logic   full;
	logic   empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frag_size         <= FRAG_SIZE_RESET;
			cfg_q.short_sequence    <= 1'b0;
			cfg_q.send_addr_ctrl    <= 1'b1;
			cfg_q.compress_protocol <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAG_SIZE:         cfg_q.frag_size         <= cfg_data[15:0];
				REG_SHORT_SEQUENCE:    cfg_q.short_sequence    <= cfg_data[0];
				REG_SEND_ADDR_CTRL:    cfg_q.send_addr_ctrl    <= cfg_data[0];
				REG_COMPRESS_PROTOCOL: cfg_q.compress_protocol <= cfg_data[0];
				default:               cfg_q <= cfg_q;
			endcase
		end
	end

	assign item_stall = full;
	assign accept     = item_valid && !full;

	mlpf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.accept (accept),
		.item   (item),
		.push   (push),
		.entry  (entry)
	);

	mlpf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.empty      (empty)
	);

	mlpf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_header |-> !result.run_last && !result.fragment_last)
		else $error("header beat carries payload marks");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.packet_last |-> result.fragment_last)
		else $error("packet ends inside a fragment");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.is_header |-> result.run_last)
		else $error("payload beat without end of run");

	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("queue full and empty at once");
`endif

endmodule
